### sv/fmu_pkg.sv
// shared constants for the fuzzy membership unit
`default_nettype none

package fmu_pkg;

  // shape register codes
  localparam logic [1:0] SHAPE_RISE = 2'd0;
  localparam logic [1:0] SHAPE_TRI  = 2'd1;
  localparam logic [1:0] SHAPE_TRAP = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BP_A  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BP_B  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BP_C  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BP_D  = 3'd4;

  // entries held between the classifier and the divider
  localparam int unsigned QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

### sv/fmu_front.sv
// classifier: picks the segment of the shape and sets up the slope ratio
`default_nettype none

module fmu_front #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned FRAC_BITS   = 15
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire [SAMPLE_BITS-1:0]  sample,
  input  wire [1:0]              shape,
  input  wire [SAMPLE_BITS-1:0]  bp_a,
  input  wire [SAMPLE_BITS-1:0]  bp_b,
  input  wire [SAMPLE_BITS-1:0]  bp_c,
  input  wire [SAMPLE_BITS-1:0]  bp_d,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic                   out_const,
  output logic [FRAC_BITS:0]     out_q,
  output logic [SAMPLE_BITS-1:0] out_n,
  output logic [SAMPLE_BITS-1:0] out_d
);
  import fmu_pkg::*;

  localparam int unsigned DIFF_W = SAMPLE_BITS + 1;
  localparam int unsigned DEG_W  = FRAC_BITS + 1;
  localparam logic [DEG_W-1:0] ONE_VALUE = {1'b1, {FRAC_BITS{1'b0}}};

  logic en;

  logic signed [SAMPLE_BITS-1:0] x, a, b, c, d, hi, lo;
  logic le_a, gt_b, ge_c, ge_d, eq_b, lt_b, le_c;
  logic signed [DIFF_W-1:0] rise_num, rise_den, fall_num, fall_den;

  logic                     c_const, c_one, c_fall;

  // first stage registers
  logic                     f1_valid;
  logic                     f1_const;
  logic                     f1_one;
  logic signed [DIFF_W-1:0] f1_num;
  logic signed [DIFF_W-1:0] f1_den;

  // second stage registers
  logic                     f2_valid;
  logic                     f2_const;
  logic [DEG_W-1:0]         f2_q;
  logic [SAMPLE_BITS-1:0]   f2_n;
  logic [SAMPLE_BITS-1:0]   f2_d;

  logic [DEG_W-1:0]         s_q;
  logic                     s_const;

  assign en       = !f2_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    x  = $signed(sample);
    a  = $signed(bp_a);
    b  = $signed(bp_b);
    c  = $signed(bp_c);
    d  = $signed(bp_d);
    hi = (shape == SHAPE_TRI) ? c : d;
    lo = (shape == SHAPE_TRI) ? b : c;

    le_a = x <= a;
    gt_b = x > b;
    ge_c = x >= c;
    ge_d = x >= d;
    eq_b = x == b;
    lt_b = x < b;
    le_c = x <= c;

    rise_num = DIFF_W'(x) - DIFF_W'(a);
    rise_den = DIFF_W'(b) - DIFF_W'(a);
    fall_num = DIFF_W'(hi) - DIFF_W'(x);
    fall_den = DIFF_W'(hi) - DIFF_W'(lo);

    c_const = 1'b1;
    c_one   = 1'b0;
    c_fall  = 1'b0;
    case (shape)
      SHAPE_RISE: begin
        if (le_a) begin
          c_const = 1'b1;
        end else if (gt_b) begin
          c_one = 1'b1;
        end else begin
          c_const = 1'b0;
        end
      end
      SHAPE_TRI: begin
        if (le_a || ge_c) begin
          c_const = 1'b1;
        end else if (eq_b) begin
          c_one = 1'b1;
        end else begin
          c_const = 1'b0;
          c_fall  = !lt_b;
        end
      end
      SHAPE_TRAP: begin
        if (le_a || ge_d) begin
          c_const = 1'b1;
        end else if (!lt_b && le_c) begin
          c_one = 1'b1;
        end else begin
          c_const = 1'b0;
          c_fall  = !lt_b;
        end
      end
      default: begin
        c_const = 1'b1;
      end
    endcase
  end

  // resolve the degenerate ratios before they reach the divider
  always_comb begin
    s_const = 1'b1;
    s_q     = '0;
    if (f1_const) begin
      s_q = f1_one ? ONE_VALUE : '0;
    end else if (f1_den <= 0 || f1_num <= 0) begin
      s_q = (f1_den == 0) ? ONE_VALUE : '0;
    end else if (f1_num >= f1_den) begin
      s_q = ONE_VALUE;
    end else begin
      s_const = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= in_valid;
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_const <= c_const;
      f1_one   <= c_one;
      f1_num   <= c_fall ? fall_num : rise_num;
      f1_den   <= c_fall ? fall_den : rise_den;
      f2_const <= s_const;
      f2_q     <= s_q;
      f2_n     <= f1_num[SAMPLE_BITS-1:0];
      f2_d     <= f1_den[SAMPLE_BITS-1:0];
    end
  end

  assign out_valid = f2_valid;
  assign out_const = f2_const;
  assign out_q     = f2_q;
  assign out_n     = f2_n;
  assign out_d     = f2_d;

endmodule

`default_nettype wire

### sv/fmu_queue.sv
// short fifo between the classifier and the divider
`default_nettype none

module fmu_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire [WIDTH-1:0]  wr_data,
  input  wire              pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty,
  output logic [$clog2(fmu_pkg::QUEUE_DEPTH+1)-1:0] count
);
  import fmu_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### sv/fmu_divider.sv
// pipelined restoring divider, one quotient bit per stage after the input register
`default_nettype none

module fmu_divider #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned FRAC_BITS   = 15
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire                    in_const,
  input  wire [FRAC_BITS:0]      in_q,
  input  wire [SAMPLE_BITS-1:0]  in_n,
  input  wire [SAMPLE_BITS-1:0]  in_d,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [FRAC_BITS:0]     degree
);
  import fmu_pkg::*;

  localparam int unsigned DEG_W = FRAC_BITS + 1;

  logic                   en;
  logic                   v  [FRAC_BITS+1];
  logic                   cf [FRAC_BITS+1];
  logic [DEG_W-1:0]       q  [FRAC_BITS+1];
  logic [SAMPLE_BITS-1:0] r  [FRAC_BITS+1];
  logic [SAMPLE_BITS-1:0] dv [FRAC_BITS+1];

  // whole pipe moves together; the last stage is the output register
  assign en       = !v[FRAC_BITS] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cf[0] <= in_const;
      q[0]  <= in_q;
      r[0]  <= in_n;
      dv[0] <= in_d;
    end
  end

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_stage
    logic [SAMPLE_BITS:0]   rs;
    logic [SAMPLE_BITS:0]   diff;
    logic                   ge;
    logic [SAMPLE_BITS-1:0] r_next;
    logic [DEG_W-1:0]       q_next;

    always_comb begin
      rs     = {r[k-1], 1'b0};
      diff   = rs - {1'b0, dv[k-1]};
      ge     = rs >= {1'b0, dv[k-1]};
      r_next = ge ? diff[SAMPLE_BITS-1:0] : rs[SAMPLE_BITS-1:0];
      q_next = {q[k-1][DEG_W-2:0], ge};
      // fixed results pass through untouched
      if (cf[k-1]) begin
        r_next = r[k-1];
        q_next = q[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cf[k] <= cf[k-1];
        q[k]  <= q_next;
        r[k]  <= r_next;
        dv[k] <= dv[k-1];
      end
    end
  end

  assign out_valid = v[FRAC_BITS];
  assign degree    = q[FRAC_BITS];

endmodule

`default_nettype wire

### sv/fuzzy_membership_unit.sv
// Fuzzy membership unit: signed sample in, membership degree out.
//
// Input stream s_axis_* carries one sample per transfer; output stream
// m_axis_* carries its degree, 2^FRAC_BITS meaning 1.0. Configuration
// writes arrive on cfg_* (index 0 shape, 1..4 breakpoints a..d) and are
// always taken; they should only be made while no sample is in flight.
// Shapes: 0 rising grade, 1 triangle, 2 trapezoid; code 3 gives 0.
//
// Two classifier stages, one queue slot and FRAC_BITS + 1 divider stages
// lie on the path; each divider stage but the first adds one quotient bit.
// Throughput is one sample per cycle unless the output stalls, set by the
// fully pipelined divider. A four-entry queue separates the classifier
// from the divider, so the input keeps flowing while the output is stalled
// until the queue fills; while m_axis_tready is low and a degree is valid,
// the divider pipe holds and the degree stays put. Reset (rst, synchronous)
// empties the pipe and queue and clears all configuration registers to zero.
`default_nettype none

module fuzzy_membership_unit #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned FRAC_BITS   = 15
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    s_axis_tvalid,
  output logic                                   s_axis_tready,
  // sample
  input  wire [((SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire                                    m_axis_tready,
  // degree
  output logic [((FRAC_BITS+8)/8)*8-1:0]         m_axis_tdata,
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire [fmu_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire [SAMPLE_BITS-1:0]                  cfg_data
);
  import fmu_pkg::*;

  localparam int unsigned DEG_W   = FRAC_BITS + 1;
  localparam int unsigned ENTRY_W = 1 + DEG_W + 2 * SAMPLE_BITS;
  localparam int unsigned OUT_W   = ((FRAC_BITS + 8) / 8) * 8;
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam logic [DEG_W-1:0] ONE_VALUE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [1:0]             shape;
  logic [SAMPLE_BITS-1:0] bp_a, bp_b, bp_c, bp_d;

  logic                   f_valid;
  logic                   f_const;
  logic [DEG_W-1:0]       f_q;
  logic [SAMPLE_BITS-1:0] f_n, f_d;

  logic                   q_full, q_empty;
  logic [CNT_W-1:0]       q_count;
  logic [ENTRY_W-1:0]     q_wr, q_rd;
  logic                   b_ready;
  logic [DEG_W-1:0]       degree;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape <= '0;
      bp_a  <= '0;
      bp_b  <= '0;
      bp_c  <= '0;
      bp_d  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SHAPE: shape <= cfg_data[1:0];
        REG_BP_A:  bp_a  <= cfg_data;
        REG_BP_B:  bp_b  <= cfg_data;
        REG_BP_C:  bp_c  <= cfg_data;
        REG_BP_D:  bp_d  <= cfg_data;
        default: ;
      endcase
    end
  end

  fmu_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sample   (s_axis_tdata[SAMPLE_BITS-1:0]),
    .shape    (shape),
    .bp_a     (bp_a),
    .bp_b     (bp_b),
    .bp_c     (bp_c),
    .bp_d     (bp_d),
    .out_valid(f_valid),
    .out_ready(!q_full),
    .out_const(f_const),
    .out_q    (f_q),
    .out_n    (f_n),
    .out_d    (f_d)
  );

  assign q_wr = {f_const, f_q, f_n, f_d};

  fmu_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (f_valid),
    .wr_data(q_wr),
    .pop    (b_ready),
    .rd_data(q_rd),
    .full   (q_full),
    .empty  (q_empty),
    .count  (q_count)
  );

  fmu_divider #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!q_empty),
    .in_ready (b_ready),
    .in_const (q_rd[ENTRY_W-1]),
    .in_q     (q_rd[ENTRY_W-2 -: DEG_W]),
    .in_n     (q_rd[2*SAMPLE_BITS-1 -: SAMPLE_BITS]),
    .in_d     (q_rd[SAMPLE_BITS-1:0]),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .degree   (degree)
  );

  assign m_axis_tdata = OUT_W'(degree);

`ifndef SYNTHESIS
  // a degree never exceeds 1.0
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> degree <= ONE_VALUE)
    else $error("degree above one");

  // the classifier never stalls the input while the queue has room
  assert property (@(posedge clk) disable iff (rst)
    !q_full |-> s_axis_tready)
    else $error("input stalled with queue space");

  // queue occupancy stays within its depth
  assert property (@(posedge clk) disable iff (rst)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue overflow");
`endif

endmodule

`default_nettype wire
